FILE: design/cest_pkg.sv
// Shared constants, types and codes for the cyclic executive slot table.
package cest_pkg;

   localparam int MaxSlots = 16;
   localparam int SlotW    = $clog2(MaxSlots);
   localparam int CountW   = $clog2(MaxSlots + 1);

   localparam int TimeW   = 64;
   localparam int BudgetW = 48;
   localparam int EndW    = 52;
   localparam int JobW    = 32;
   localparam int StatusW = 4;
   localparam int OpW     = 3;

   // operation codes
   localparam logic [OpW-1:0] OP_CLEAR    = 3'd0;
   localparam logic [OpW-1:0] OP_APPEND   = 3'd1;
   localparam logic [OpW-1:0] OP_ADMIT    = 3'd2;
   localparam logic [OpW-1:0] OP_RELEASE  = 3'd3;
   localparam logic [OpW-1:0] OP_ZERO     = 3'd4;
   localparam logic [OpW-1:0] OP_TICK     = 3'd5;
   localparam logic [OpW-1:0] OP_COMPLETE = 3'd6;

   // status codes
   localparam logic [StatusW-1:0] ST_OK         = 4'd0;
   localparam logic [StatusW-1:0] ST_BAD_BUDGET = 4'd1;
   localparam logic [StatusW-1:0] ST_FULL       = 4'd2;
   localparam logic [StatusW-1:0] ST_RANGE      = 4'd3;
   localparam logic [StatusW-1:0] ST_OCCUPIED   = 4'd4;
   localparam logic [StatusW-1:0] ST_COST       = 4'd5;
   localparam logic [StatusW-1:0] ST_EMPTY      = 4'd6;
   localparam logic [StatusW-1:0] ST_BEHIND     = 4'd7;
   localparam logic [StatusW-1:0] ST_EARLY      = 4'd8;
   localparam logic [StatusW-1:0] ST_FREE       = 4'd9;

   // configuration register indexes
   localparam logic [0:0] CSR_START    = 1'b0;
   localparam logic [0:0] CSR_RELEASED = 1'b1;

   // one slot entry as stored in the memory
   typedef struct packed {
      logic [BudgetW-1:0] budget;
      logic [EndW-1:0]    end_time;
      logic               occupied;
      logic [JobW-1:0]    expected;
   } slot_entry_type;

   // divider handshake
   typedef struct packed {
      logic             start;
      logic [TimeW-1:0] dividend;
      logic [EndW-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [EndW-1:0] remainder;
   } div_rsp_type;

endpackage

FILE: design/cest_slot_mem.sv
// Slot table memory: one write port, one registered read port.
module cest_slot_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [cest_pkg::SlotW-1:0] wr_addr,
   input  cest_pkg::slot_entry_type   wr_data,
   input  logic [cest_pkg::SlotW-1:0] rd_addr,
   output cest_pkg::slot_entry_type   rd_data
);
   import cest_pkg::*;

   slot_entry_type mem [MaxSlots];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/cest_mod_unit.sv
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
module cest_mod_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  cest_pkg::div_req_type div_req,
   output cest_pkg::div_rsp_type div_rsp
);
   import cest_pkg::*;

   localparam int CntW = $clog2(TimeW + 1);

   logic [TimeW-1:0] dividend_ff, dividend_in;
   logic [EndW:0]    rem_ff, rem_in;
   logic [EndW-1:0]  divisor_ff, divisor_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [EndW:0]    shifted;

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      shifted     = {rem_ff[EndW-1:0], dividend_ff[TimeW-1]};
      if (div_req.start) begin
         dividend_in = div_req.dividend;
         divisor_in  = div_req.divisor;
         rem_in      = '0;
         count_in    = CntW'(TimeW);
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         // restoring step: shift one dividend bit in, subtract if it fits
         dividend_in = {dividend_ff[TimeW-2:0], 1'b0};
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in = shifted - {1'b0, divisor_ff};
         end else begin
            rem_in = shifted;
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff[EndW-1:0];

endmodule

FILE: design/cyclic_executive_slot_table_unit.sv
// Top level of the cyclic executive slot table: control sequencer and result register.
//
//  Channel  Ports      Direction  Payload
//  req      req_*      in         operation, budget, slot, cost, time, job
//  rsp      rsp_*      out        status, slot, marks, event times, counter, flags
//  csr      csr_*      in         cycle_start_time (0), schedule_released (1)
//
// One item at a time. Append, admit, release and complete pass through the read, execute
// and output states; an unknown operation or a tick on an empty table goes from read to
// output; clear sweeps all MaxSlots entries; zero-counters does a read-modify-write of all
// MaxSlots entries. A tick waits for the serial remainder, then searches linearly for its
// slot; before the start time it skips the remainder and searches from offset zero.
// Reset clears control state and the slot table through a sweep of all MaxSlots entries,
// during which no item is accepted. A held result stalls the next accept.
module cyclic_executive_slot_table_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cest_pkg::OpW-1:0]         req_operation,
   input  logic [cest_pkg::BudgetW-1:0]     req_slot_budget,
   input  logic [cest_pkg::SlotW-1:0]       req_slot_number,
   input  logic [cest_pkg::BudgetW-1:0]     req_task_cost,
   input  logic [cest_pkg::TimeW-1:0]       req_current_time,
   input  logic [cest_pkg::JobW-1:0]        req_job_number,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cest_pkg::StatusW-1:0]     rsp_status,
   output logic [cest_pkg::SlotW-1:0]       rsp_chosen_slot,
   output logic                             rsp_slot_occupied,
   output logic [cest_pkg::TimeW-1:0]       rsp_next_event_time,
   output logic [cest_pkg::TimeW-1:0]       rsp_release_time,
   output logic [cest_pkg::JobW-1:0]        rsp_expected_job_out,
   output logic                             rsp_overrun,
   output logic                             rsp_time_before_start,
   input  logic                             csr_write_enable,
   input  logic [0:0]                       csr_index,
   input  logic [cest_pkg::TimeW-1:0]       csr_write_data
);
   import cest_pkg::*;

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_READ   = 4'd2;
   localparam logic [3:0] S_EXEC   = 4'd3;
   localparam logic [3:0] S_SWEEP  = 4'd4;
   localparam logic [3:0] S_MOD    = 4'd5;
   localparam logic [3:0] S_SREAD  = 4'd6;
   localparam logic [3:0] S_SCHK   = 4'd7;
   localparam logic [3:0] S_TFIN   = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   logic [3:0] state_ff, state_in;

   // configuration
   logic [TimeW-1:0] start_ff, start_in;
   logic             released_ff, released_in;

   // table bookkeeping
   logic [CountW-1:0] count_ff, count_in;
   logic [EndW-1:0]   length_ff, length_in;

   // captured request
   logic [OpW-1:0]     op_ff, op_in;
   logic [BudgetW-1:0] budget_ff, budget_in;
   logic [SlotW-1:0]   slot_ff, slot_in;
   logic [BudgetW-1:0] cost_ff, cost_in;
   logic [TimeW-1:0]   now_ff, now_in;
   logic [JobW-1:0]    job_ff, job_in;

   // sweep / search
   logic [SlotW-1:0] idx_ff, idx_in;
   logic [EndW-1:0]  offset_ff, offset_in;
   logic             before_ff, before_in;

   // result register
   logic               rv_ff, rv_in;
   logic [StatusW-1:0] r_status_ff, r_status_in;
   logic [SlotW-1:0]   r_slot_ff, r_slot_in;
   logic               r_occ_ff, r_occ_in;
   logic [TimeW-1:0]   r_next_ff, r_next_in;
   logic [TimeW-1:0]   r_rel_ff, r_rel_in;
   logic [JobW-1:0]    r_exp_ff, r_exp_in;
   logic               r_ovr_ff, r_ovr_in;
   logic               r_bef_ff, r_bef_in;

   // memory ports
   logic            wr_en;
   logic [SlotW-1:0] wr_addr, rd_addr;
   slot_entry_type  wr_data, rd_data;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic        req_xfer, rsp_xfer;
   logic [TimeW-1:0] next_ev;
   logic [CountW-1:0] last_idx;
   logic        in_range;

   cest_slot_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cest_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rv_ff && !rsp_stall;
   assign in_range  = {1'b0, slot_ff} < count_ff;
   assign last_idx  = count_ff - 1'b1;
   assign next_ev   = (now_ff - TimeW'(offset_ff)) + TimeW'(rd_data.end_time);

   always_comb begin
      state_in    = state_ff;
      start_in    = start_ff;
      released_in = released_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      op_in       = op_ff;
      budget_in   = budget_ff;
      slot_in     = slot_ff;
      cost_in     = cost_ff;
      now_in      = now_ff;
      job_in      = job_ff;
      idx_in      = idx_ff;
      offset_in   = offset_ff;
      before_in   = before_ff;
      rv_in       = rv_ff;
      r_status_in = r_status_ff;
      r_slot_in   = r_slot_ff;
      r_occ_in    = r_occ_ff;
      r_next_in   = r_next_ff;
      r_rel_in    = r_rel_ff;
      r_exp_in    = r_exp_ff;
      r_ovr_in    = r_ovr_ff;
      r_bef_in    = r_bef_ff;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = rd_data;
      rd_addr     = slot_ff;
      div_req.start    = 1'b0;
      div_req.dividend = now_ff - start_ff;
      div_req.divisor  = length_ff;

      if (rsp_xfer) begin
         rv_in = 1'b0;
      end

      // configuration writes
      if (csr_write_enable) begin
         if (csr_index == CSR_START) begin
            start_in = csr_write_data;
         end else begin
            released_in = csr_write_data[0];
         end
      end

      unique case (state_ff) inside
         S_INIT, S_SWEEP: begin
            // clear whole entries, or only counters for zero-counters
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (state_ff == S_SWEEP && op_ff == OP_ZERO) begin
               rd_addr = idx_ff;
               wr_en   = 1'b0;
               state_in = S_TFIN;
            end else begin
               wr_data = '0;
               idx_in  = idx_ff + 1'b1;
               if (idx_ff == SlotW'(MaxSlots - 1)) begin
                  idx_in   = '0;
                  state_in = (state_ff == S_INIT) ? S_IDLE : S_OUT;
               end
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               op_in     = req_operation;
               budget_in = req_slot_budget;
               slot_in   = req_slot_number;
               cost_in   = req_task_cost;
               now_in    = req_current_time;
               job_in    = req_job_number;
               idx_in    = '0;
               r_status_in = ST_OK;
               r_slot_in   = '0;
               r_occ_in    = 1'b0;
               r_next_in   = '0;
               r_rel_in    = '0;
               r_exp_in    = '0;
               r_ovr_in    = 1'b0;
               r_bef_in    = 1'b0;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            // issue the memory read of the addressed entry
            case (op_ff)
               OP_APPEND: rd_addr = count_ff[SlotW-1:0];
               default:   rd_addr = slot_ff;
            endcase
            case (op_ff) inside
               OP_CLEAR: begin
                  count_in  = '0;
                  length_in = '0;
                  state_in  = S_SWEEP;
               end
               OP_ZERO: state_in = S_SWEEP;
               OP_TICK: begin
                  if (count_ff == '0 || length_ff == '0) begin
                     r_status_in = ST_EMPTY;
                     state_in    = S_OUT;
                  end else if (now_ff < start_ff) begin
                     before_in = 1'b1;
                     offset_in = '0;
                     idx_in    = '0;
                     state_in  = S_SREAD;
                  end else begin
                     before_in     = 1'b0;
                     div_req.start = 1'b1;
                     state_in      = S_MOD;
                  end
               end
               OP_ADMIT, OP_RELEASE, OP_COMPLETE, OP_APPEND: state_in = S_EXEC;
               default: state_in = S_OUT;
            endcase
         end
         S_EXEC: begin
            wr_data = rd_data;
            case (op_ff)
               OP_APPEND: begin
                  if (budget_ff == '0) begin
                     r_status_in = ST_BAD_BUDGET;
                  end else if (count_ff >= CountW'(MaxSlots)) begin
                     r_status_in = ST_FULL;
                  end else begin
                     wr_en            = 1'b1;
                     wr_addr          = count_ff[SlotW-1:0];
                     wr_data.budget   = budget_ff;
                     wr_data.end_time = length_ff + EndW'(budget_ff);
                     length_in        = length_ff + EndW'(budget_ff);
                     count_in         = count_ff + 1'b1;
                     r_slot_in        = count_ff[SlotW-1:0];
                     r_occ_in         = rd_data.occupied;
                  end
               end
               default: begin
                  r_slot_in = slot_ff;
                  if (!in_range) begin
                     r_status_in = ST_RANGE;
                  end else begin
                     r_occ_in = rd_data.occupied;
                     if (op_ff == OP_ADMIT) begin
                        if (rd_data.occupied) begin
                           r_status_in = ST_OCCUPIED;
                        end else if (cost_ff >= rd_data.budget) begin
                           r_status_in = ST_COST;
                        end else begin
                           wr_en            = 1'b1;
                           wr_data.occupied = 1'b1;
                           r_occ_in         = 1'b1;
                        end
                     end else if (op_ff == OP_RELEASE) begin
                        if (!rd_data.occupied) begin
                           r_status_in = ST_FREE;
                        end else begin
                           wr_en            = 1'b1;
                           wr_data.occupied = 1'b0;
                           r_occ_in         = 1'b0;
                        end
                     end else begin
                        r_exp_in = rd_data.expected;
                        if (job_ff < rd_data.expected) begin
                           r_status_in = ST_BEHIND;
                        end else if (rd_data.expected < job_ff) begin
                           r_status_in = ST_EARLY;
                        end
                     end
                  end
               end
            endcase
            state_in = S_OUT;
         end
         S_MOD: begin
            if (div_rsp.done) begin
               offset_in = div_rsp.remainder;
               idx_in    = '0;
               state_in  = S_SREAD;
            end
         end
         S_SREAD: begin
            rd_addr  = idx_ff;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            // first slot whose end lies past the offset, else the last one
            rd_addr = idx_ff;
            if (offset_ff < rd_data.end_time
                || {1'b0, idx_ff} == last_idx) begin
               wr_addr   = idx_ff;
               r_slot_in = idx_ff;
               r_occ_in  = rd_data.occupied;
               r_bef_in  = before_ff;
               r_next_in = next_ev;
               r_rel_in  = next_ev - TimeW'(rd_data.budget);
               r_exp_in  = rd_data.expected;
               if (rd_data.occupied && released_ff) begin
                  wr_en            = 1'b1;
                  wr_data.expected = rd_data.expected + 1'b1;
                  r_exp_in         = rd_data.expected + 1'b1;
                  r_ovr_in         = (rd_data.expected + 1'b1) != job_ff;
               end
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SREAD;
            end
         end
         S_TFIN: begin
            // zero-counters: read-modify-write of each entry
            wr_en            = 1'b1;
            wr_addr          = idx_ff;
            wr_data.expected = '0;
            rd_addr          = idx_ff;
            idx_in           = idx_ff + 1'b1;
            if (idx_ff == SlotW'(MaxSlots - 1)) begin
               idx_in   = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_SWEEP;
            end
         end
         S_OUT: begin
            rv_in    = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         start_ff    <= '0;
         released_ff <= 1'b0;
         count_ff    <= '0;
         length_ff   <= '0;
         idx_ff      <= '0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         start_ff    <= start_in;
         released_ff <= released_in;
         count_ff    <= count_in;
         length_ff   <= length_in;
         idx_ff      <= idx_in;
         rv_ff       <= rv_in;
      end
      op_ff       <= op_in;
      budget_ff   <= budget_in;
      slot_ff     <= slot_in;
      cost_ff     <= cost_in;
      now_ff      <= now_in;
      job_ff      <= job_in;
      offset_ff   <= offset_in;
      before_ff   <= before_in;
      r_status_ff <= r_status_in;
      r_slot_ff   <= r_slot_in;
      r_occ_ff    <= r_occ_in;
      r_next_ff   <= r_next_in;
      r_rel_ff    <= r_rel_in;
      r_exp_ff    <= r_exp_in;
      r_ovr_ff    <= r_ovr_in;
      r_bef_ff    <= r_bef_in;
   end

   assign rsp_valid             = rv_ff;
   assign rsp_status            = r_status_ff;
   assign rsp_chosen_slot       = r_slot_ff;
   assign rsp_slot_occupied     = r_occ_ff;
   assign rsp_next_event_time   = r_next_ff;
   assign rsp_release_time      = r_rel_ff;
   assign rsp_expected_job_out  = r_exp_ff;
   assign rsp_overrun           = r_ovr_ff;
   assign rsp_time_before_start = r_bef_ff;

   // slot count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxSlots))
      else $error("slot count beyond table size");

   // no new transfer is accepted while a result is held
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_xfer)
      else $error("request accepted while result pending");

   // a result appears only after leaving the output state
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside output state");

endmodule

FILE: bench/cyclic_executive_slot_table_unit_tb.sv
// Self-checking testbench for the cyclic executive slot table unit.
`timescale 1ns / 1ps

module cyclic_executive_slot_table_unit_tb;
   import cest_pkg::*;

   localparam int RandomItems = 800;
   localparam longint CycleLimit = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OpW-1:0] req_operation = '0;
   logic [BudgetW-1:0] req_slot_budget = '0;
   logic [SlotW-1:0] req_slot_number = '0;
   logic [BudgetW-1:0] req_task_cost = '0;
   logic [TimeW-1:0] req_current_time = '0;
   logic [JobW-1:0] req_job_number = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [StatusW-1:0] rsp_status;
   logic [SlotW-1:0] rsp_chosen_slot;
   logic rsp_slot_occupied;
   logic [TimeW-1:0] rsp_next_event_time;
   logic [TimeW-1:0] rsp_release_time;
   logic [JobW-1:0] rsp_expected_job_out;
   logic rsp_overrun;
   logic rsp_time_before_start;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = '0;
   logic [TimeW-1:0] csr_write_data = '0;

   typedef struct packed {
      logic [OpW-1:0] op;
      logic [BudgetW-1:0] budget;
      logic [SlotW-1:0] slot;
      logic [BudgetW-1:0] cost;
      logic [TimeW-1:0] now;
      logic [JobW-1:0] job;
   } sched_cmd_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [SlotW-1:0] chosen;
      logic occ;
      logic [TimeW-1:0] next_ev;
      logic [TimeW-1:0] rel;
      logic [JobW-1:0] expected;
      logic overrun;
      logic pre_start;
   } sched_rsp_type;

   // directed row: command plus an optional typed-in answer
   typedef struct {
      sched_cmd_type cmd;
      bit known;
      sched_rsp_type answer;
   } directed_row_type;

   cyclic_executive_slot_table_unit u_dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [TimeW-1:0] start_time_q;
   logic released_q;
   logic [BudgetW-1:0] budgets [MaxSlots];
   logic [EndW-1:0] end_times [MaxSlots];
   logic occupied [MaxSlots];
   logic [JobW-1:0] job_counters [MaxSlots];
   int unsigned used_slots;
   logic [EndW-1:0] cycle_len;

   sched_rsp_type pending_rsps[$];
   int error_count = 0;
   int rsp_count = 0;
   int rsp_gap_left = 0;
   longint cycle_count = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("MISMATCH rsp %0d %s: got %0h want %0h", rsp_count, what, got, want);
   endtask

   function automatic void clear_schedule();
      for (int i = 0; i < MaxSlots; i++) begin
         budgets[i] = '0;
         end_times[i] = '0;
         occupied[i] = 1'b0;
         job_counters[i] = '0;
      end
      used_slots = 0;
      cycle_len = '0;
   endfunction

   // work out the answer to one command and update the schedule
   function automatic sched_rsp_type schedule_step(input sched_cmd_type c);
      sched_rsp_type r;
      logic [TimeW-1:0] offset;
      int idx;
      r = '0;
      case (c.op) inside
         OP_CLEAR: clear_schedule();
         OP_APPEND: begin
            if (c.budget == 0) r.status = ST_BAD_BUDGET;
            else if (used_slots >= MaxSlots) r.status = ST_FULL;
            else begin
               budgets[used_slots] = c.budget;
               end_times[used_slots] = cycle_len + c.budget;
               cycle_len = cycle_len + c.budget;
               r.chosen = used_slots[SlotW-1:0];
               r.occ = occupied[used_slots];
               used_slots++;
            end
         end
         OP_ADMIT, OP_RELEASE, OP_COMPLETE: begin
            r.chosen = c.slot;
            if (c.slot >= used_slots) r.status = ST_RANGE;
            else begin
               if (c.op == OP_ADMIT) begin
                  if (occupied[c.slot]) r.status = ST_OCCUPIED;
                  else if (c.cost >= budgets[c.slot]) r.status = ST_COST;
                  else occupied[c.slot] = 1'b1;
               end else if (c.op == OP_RELEASE) begin
                  if (!occupied[c.slot]) r.status = ST_FREE;
                  else occupied[c.slot] = 1'b0;
               end else begin
                  r.expected = job_counters[c.slot];
                  if (c.job < job_counters[c.slot]) r.status = ST_BEHIND;
                  else if (c.job > job_counters[c.slot]) r.status = ST_EARLY;
               end
               r.occ = occupied[c.slot];
            end
         end
         OP_ZERO: for (int i = 0; i < MaxSlots; i++) job_counters[i] = '0;
         OP_TICK: begin
            if (used_slots == 0 || cycle_len == 0) r.status = ST_EMPTY;
            else begin
               offset = '0;
               if (c.now < start_time_q) r.pre_start = 1'b1;
               else offset = (c.now - start_time_q) % {12'd0, cycle_len};
               idx = used_slots - 1;
               for (int i = 0; i < used_slots; i++)
                  if (offset < {12'd0, end_times[i]}) begin
                     idx = i;
                     break;
                  end
               r.next_ev = (c.now - offset) + {12'd0, end_times[idx]};
               r.rel = r.next_ev - {16'd0, budgets[idx]};
               r.chosen = idx[SlotW-1:0];
               r.occ = occupied[idx];
               if (occupied[idx] && released_q) begin
                  job_counters[idx] = job_counters[idx] + 1;
                  r.overrun = job_counters[idx] != c.job;
               end
               r.expected = job_counters[idx];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic sched_cmd_type make_cmd(input logic [OpW-1:0] op,
         input logic [BudgetW-1:0] budget, input logic [SlotW-1:0] slot,
         input logic [BudgetW-1:0] cost, input logic [TimeW-1:0] now,
         input logic [JobW-1:0] job);
      sched_cmd_type c;
      c.op = op; c.budget = budget; c.slot = slot;
      c.cost = cost; c.now = now; c.job = job;
      return c;
   endfunction

   function automatic logic [TimeW-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [BudgetW-1:0] rand48();
      return BudgetW'({$urandom(), $urandom()});
   endfunction

   function automatic logic [SlotW-1:0] rand_slot();
      return SlotW'($urandom());
   endfunction

   // mostly short gaps, sometimes long
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_cmd(input sched_cmd_type c, input bit known,
                           input sched_rsp_type answer);
      sched_rsp_type want;
      int gap;
      want = schedule_step(c);
      if (known && want !== answer) begin
         error_count++;
         $display("MISMATCH table row for op %0d disagrees with prediction", c.op);
      end
      pending_rsps.push_back(want);
      req_valid <= 1'b1;
      req_operation <= c.op;
      req_slot_budget <= c.budget;
      req_slot_number <= c.slot;
      req_task_cost <= c.cost;
      req_current_time <= c.now;
      req_job_number <= c.job;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send(input sched_cmd_type c);
      send_cmd(c, 1'b0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] index, input logic [TimeW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_START) start_time_q = data;
      else released_q = data[0];
   endtask

   // result side: random stall runs and check against oldest expectation
   always @(posedge clock) begin
      sched_rsp_type want;
      cycle_count++;
      if (!reset) begin
         if (rsp_gap_left == 0) rsp_gap_left = gap_len() + 1;
         rsp_gap_left--;
         rsp_stall <= (rsp_gap_left != 0);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            error_count++;
            $display("MISMATCH unexpected transfer on rsp");
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_chosen_slot !== want.chosen)
               report_mismatch("chosen_slot", rsp_chosen_slot, want.chosen);
            if (rsp_slot_occupied !== want.occ)
               report_mismatch("slot_occupied", rsp_slot_occupied, want.occ);
            if (rsp_next_event_time !== want.next_ev)
               report_mismatch("next_event_time", rsp_next_event_time, want.next_ev);
            if (rsp_release_time !== want.rel)
               report_mismatch("release_time", rsp_release_time, want.rel);
            if (rsp_expected_job_out !== want.expected)
               report_mismatch("expected_job_out", rsp_expected_job_out, want.expected);
            if (rsp_overrun !== want.overrun)
               report_mismatch("overrun", rsp_overrun, want.overrun);
            if (rsp_time_before_start !== want.pre_start)
               report_mismatch("time_before_start", rsp_time_before_start,
                               want.pre_start);
            rsp_count++;
         end
      end
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // random phase: schedules built from appends, mixed at random with ticks and job traffic
   task automatic random_phase(input int items);
      sched_cmd_type c;
      int pick;
      logic [BudgetW-1:0] b;
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) c = make_cmd(OP_CLEAR, rand48(), rand_slot(), rand48(), rand64(),
                                    $urandom());
         else if (pick < 18) begin
            b = ($urandom_range(0, 9) == 0) ? rand48() :
                BudgetW'($urandom_range(0, 5000));
            c = make_cmd(OP_APPEND, b, rand_slot(), rand48(), rand64(), $urandom());
         end else if (pick < 35) begin
            b = ($urandom_range(0, 9) == 0) ? rand48() :
                BudgetW'($urandom_range(0, 3000));
            c = make_cmd(OP_ADMIT, rand48(), SlotW'($urandom_range(0, used_slots < 16 ?
                          used_slots : 15)), b, rand64(), $urandom());
         end else if (pick < 43)
            c = make_cmd(OP_RELEASE, rand48(), rand_slot(), rand48(), rand64(), $urandom());
         else if (pick < 46)
            c = make_cmd(OP_ZERO, rand48(), rand_slot(), rand48(), rand64(), $urandom());
         else if (pick < 80)
            c = make_cmd(OP_TICK, rand48(), rand_slot(), rand48(),
                         ($urandom_range(0, 4) == 0) ? rand64() :
                         start_time_q + $urandom_range(0, 200000) - 1000,
                         ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 6));
         else if (pick < 98)
            c = make_cmd(OP_COMPLETE, rand48(), rand_slot(), rand48(), rand64(),
                         ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 6));
         else
            c = make_cmd(3'd7, rand48(), rand_slot(), rand48(), rand64(), $urandom());
         send(c);
      end
   endtask

   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      sched_rsp_type ok;
      ok = '0;
      clear_schedule();
      start_time_q = '0;
      released_q = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: empty, extremes, errors, full table
      row.known = 1'b1;
      row.answer = ok; row.answer.status = ST_EMPTY;
      row.cmd = make_cmd(OP_TICK, '0, '0, '0, '1, '1); rows.push_back(row);
      row.answer = ok; row.answer.status = ST_BAD_BUDGET;
      row.cmd = make_cmd(OP_APPEND, '0, '1, '1, '0, '0); rows.push_back(row);
      row.answer = ok; row.answer.status = ST_RANGE; row.answer.chosen = 4'd15;
      row.cmd = make_cmd(OP_ADMIT, '1, 4'd15, '0, '0, '0); rows.push_back(row);
      row.cmd = make_cmd(OP_RELEASE, '1, 4'd15, '0, '0, '0); rows.push_back(row);
      row.cmd = make_cmd(OP_COMPLETE, '1, 4'd15, '0, '0, '1); rows.push_back(row);
      row.answer = ok;
      row.cmd = make_cmd(3'd7, '1, '1, '1, '1, '1); rows.push_back(row);
      row.cmd = make_cmd(OP_APPEND, '1, '0, '0, '0, '0); rows.push_back(row);
      row.known = 1'b0;
      for (int i = 0; i < 15; i++) begin
         row.cmd = make_cmd(OP_APPEND, 48'd1000 + i, '0, '0, '0, '0);
         rows.push_back(row);
      end
      row.known = 1'b1; row.answer = ok; row.answer.status = ST_FULL;
      row.cmd = make_cmd(OP_APPEND, 48'd5, '0, '0, '0, '0); rows.push_back(row);
      row.answer = ok; row.answer.status = ST_COST; row.answer.chosen = 4'd1;
      row.cmd = make_cmd(OP_ADMIT, '0, 4'd1, 48'd1001, '0, '0); rows.push_back(row);
      row.known = 1'b0;
      row.cmd = make_cmd(OP_ADMIT, '0, 4'd0, '1 - 1, '0, '0); rows.push_back(row);
      row.cmd = make_cmd(OP_ADMIT, '0, 4'd0, '0, '0, '0); rows.push_back(row);
      row.cmd = make_cmd(OP_TICK, '0, '0, '0, '1, '1); rows.push_back(row);
      row.cmd = make_cmd(OP_COMPLETE, '0, 4'd0, '0, '0, 32'd3); rows.push_back(row);
      foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].known, rows[i].answer);
      drain();

      // released and unreleased schedules at several start times, extremes included
      write_csr(CSR_RELEASED, 64'd1);
      write_csr(CSR_START, 64'd0);
      send(make_cmd(OP_TICK, '0, '0, '0, 64'd500, 32'd1));
      send(make_cmd(OP_COMPLETE, '0, 4'd0, '0, '0, 32'd0));
      send(make_cmd(OP_CLEAR, '0, '0, '0, '0, '0));
      random_phase(RandomItems / 4);
      drain();
      write_csr(CSR_START, 64'hFFFF_FFFF_FFFF_FFFF);
      random_phase(RandomItems / 4);
      drain();
      write_csr(CSR_RELEASED, 64'd0);
      write_csr(CSR_START, rand64() >> $urandom_range(0, 63));
      random_phase(RandomItems / 4);
      drain();
      write_csr(CSR_RELEASED, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_START, 64'd123456789);
      random_phase(RandomItems / 4);
      drain();

      $display("covered %0d checked transfers: directed table, 4 csr settings, random ops",
               rsp_count);
      if (error_count == 0 && pending_rsps.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d transfers outstanding", error_count,
                  pending_rsps.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
